[sv/stme_pkg.sv]
`default_nettype none
// ============================================================================
// Scrolling text engine package
// Shared constants, function and command codes, the 5x7 font and the control
// structure that drives the column shift line.
// ============================================================================
package stme_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_DEVICES_DEF = 8;
    localparam int MSG_DEPTH_DEF   = 256;

    // Field and register widths.
    localparam int FUNC_W      = 2;
    localparam int SLOT_W      = 8;
    localparam int CODE_W      = 7;
    localparam int PERIOD_W    = 16;
    localparam int DEVCNT_W    = 4;
    localparam int MSG_LEN_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COL_DATA_W  = 8;
    localparam int FONT_COL_W  = 3;
    localparam int CHAIN_W     = 3;
    localparam int ROW_ADDR_W  = 4;

    localparam int ROWS_PER_DEV = 8;

    // Font range and geometry.
    localparam logic [CODE_W-1:0]     GLYPH_FIRST = 7'd32;
    localparam logic [CODE_W-1:0]     GLYPH_LAST  = 7'd126;
    localparam logic [FONT_COL_W-1:0] GLYPH_COLS  = 3'd5;
    localparam logic [COL_DATA_W-1:0] BLANK_COL   = 8'h00;
    localparam int                    GLYPH_COUNT = 95;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LENGTH = 2'd3;

    // Control from the sequencer to the column shift line.
    typedef struct packed {
        logic                  shift;   // move every active column one place left
        logic                  append;  // top column takes data, else wraps the head
        logic [COL_DATA_W-1:0] data;
    } col_ctl_t;

    // Five glyph columns per printable code, first column in the top byte.
    localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0371090503,
        40'h3649494936, 40'h064949291E, 40'h006C6C0000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F4949493E, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494949, 40'h7F09090901, 40'h3E4149493A,
        40'h7F0808087F, 40'h41417F4141, 40'h3041413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09091966, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h0F3040300F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h7F41410000,
        40'h0204081020, 40'h000041417F, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7804080478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h0814147C00, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0804040804
    };

    // One column of a character; non-printable codes give blank columns.
    function automatic logic [COL_DATA_W-1:0] glyph_col(
        input logic [CODE_W-1:0]     code,
        input logic [FONT_COL_W-1:0] col
    );
        logic [39:0]           row;
        logic [COL_DATA_W-1:0] res;
        row = 40'h0;
        res = BLANK_COL;
        if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
            row = GLYPH_ROM[code - GLYPH_FIRST];
        end
        case (col)
            3'd0:    res = row[39:32];
            3'd1:    res = row[31:24];
            3'd2:    res = row[23:16];
            3'd3:    res = row[15:8];
            3'd4:    res = row[7:0];
            default: res = BLANK_COL;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/stme_ram.sv]
`default_nettype none
// ============================================================================
// Generic single-port RAM
// One write or one read per cycle; read data is registered and holds
// until the next read.
// ============================================================================
module stme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/stme_column_line.sv]
`default_nettype none
// ============================================================================
// Column shift line
// Holds the display columns. One shift moves the active columns one place
// left; the top active column takes new data or the old head column.
// ============================================================================
module stme_column_line
    import stme_pkg::*;
#(
    parameter int NUM_COLS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire col_ctl_t                      ctl,
    input  wire logic [$clog2(NUM_COLS)-1:0]   top_idx,
    output logic      [COL_DATA_W-1:0]         head
);

    localparam int IDX_W = $clog2(NUM_COLS);

    logic [COL_DATA_W-1:0] col_reg   [NUM_COLS];
    logic [COL_DATA_W-1:0] col_next  [NUM_COLS];
    logic [COL_DATA_W-1:0] right_nb  [NUM_COLS];
    logic [COL_DATA_W-1:0] top_value;

    // Right-hand neighbor of each column; the last column never shifts from it.
    for (genvar g = 0; g < NUM_COLS; g++)
    begin : g_nb
        if (g < NUM_COLS - 1)
        begin : g_inner
            assign right_nb[g] = col_reg[g+1];
        end
        else
        begin : g_end
            assign right_nb[g] = col_reg[g];
        end
    end

    assign top_value = ctl.append ? ctl.data : col_reg[0];

    always_comb
    begin
        for (int i = 0; i < NUM_COLS; i++)
        begin
            col_next[i] = col_reg[i];
            if (ctl.shift)
            begin
                if (IDX_W'(i) < top_idx)
                begin
                    col_next[i] = right_nb[i];
                end
                else if (IDX_W'(i) == top_idx)
                begin
                    col_next[i] = top_value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COLS; i++)
            begin
                col_reg[i] <= BLANK_COL;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_COLS; i++)
            begin
                col_reg[i] <= col_next[i];
            end
        end
    end

    assign head = col_reg[0];

endmodule
`default_nettype wire

[sv/scrolling_text_matrix_engine.sv]
`default_nettype none
// ============================================================================
// Scrolling text matrix engine
// Scrolls a stored message across a chain of 8x8 LED matrix devices and
// produces one row frame per device and row after every scroll step.
// ============================================================================
// Items on the input channel are ticks, message character writes and a start
// command. Writes, start items and ticks that fire no scroll step are taken
// in the idle state, and the engine stays there. A tick that fires a step
// works over N active devices: device_count, with zero taken as one device
// and counts beyond the built chain taken as its full length. The accepting
// cycle reads the current character from the message RAM, the shift state
// appends the new column to the column shift line, and then the emit state
// delivers one row frame per cycle while the receiver is ready, 8 * N in
// all, rotating through all active columns so that it ends where it began.
// The input is not ready during that time. The column store resets at once
// with the block reset, so no clearing pass follows reset; the message RAM
// has no reset and its entries must be written before they are shown.
// ============================================================================
module scrolling_text_matrix_engine
    import stme_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF,
    parameter int MSG_DEPTH   = MSG_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input item channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [SLOT_W-1:0]     char_slot,
    input  wire logic [CODE_W-1:0]     char_code,
    // Row frame channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [CHAIN_W-1:0]         chain_position,
    output logic [ROW_ADDR_W-1:0]      row_address,
    output logic [COL_DATA_W-1:0]      row_data,
    output logic                       last
);

    localparam int NUM_COLS  = MAX_DEVICES * ROWS_PER_DEV;
    localparam int COL_W     = $clog2(NUM_COLS);
    localparam int MSG_AW    = $clog2(MSG_DEPTH);
    localparam int SLOT_NUM  = 1 << SLOT_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    // Configuration registers.
    logic [PERIOD_W-1:0]   scroll_period_reg;
    logic [DEVCNT_W-1:0]   device_count_reg;
    logic                  scroll_enable_reg;
    logic [MSG_LEN_W-1:0]  message_length_reg;

    // Scroll state.
    logic [1:0]            state_reg, state_next;
    logic [PERIOD_W-1:0]   tick_count_reg, tick_count_next;
    logic [SLOT_W-1:0]     char_index_reg, char_index_next;
    logic [FONT_COL_W-1:0] font_column_reg, font_column_next;
    logic                  running_reg, running_next;
    logic                  blank_reg, blank_next;
    logic [FONT_COL_W-1:0] col_sel_reg, col_sel_next;
    logic [COL_W-1:0]      frame_reg, frame_next;

    logic                  in_fire;
    logic                  out_fire;
    logic                  step_fire;
    logic [MSG_LEN_W-1:0]  idx_step;
    logic                  blank_step;

    logic [DEVCNT_W-1:0]   active_devs;
    logic [6:0]            active_width;
    logic [COL_W-1:0]      top_idx;
    logic [COL_W-1:0]      frame_dev;

    logic                  ram_we;
    logic                  ram_re;
    logic [MSG_AW-1:0]     ram_addr;
    logic [CODE_W-1:0]     ram_rdata;

    col_ctl_t              col_ctl;
    logic [COL_DATA_W-1:0] col_head;

    // Message slots fold onto the store depth; the map is built at elaboration.
    logic [MSG_AW-1:0]     slot_map [SLOT_NUM];

    for (genvar s = 0; s < SLOT_NUM; s++)
    begin : g_slot_map
        assign slot_map[s] = MSG_AW'(s % MSG_DEPTH);
    end

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_period_reg  <= '0;
            device_count_reg   <= DEVCNT_W'(1);
            scroll_enable_reg  <= 1'b0;
            message_length_reg <= MSG_LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCROLL_PERIOD:  scroll_period_reg  <= cfg_data;
                CFG_DEVICE_COUNT:   device_count_reg   <= cfg_data[DEVCNT_W-1:0];
                CFG_SCROLL_ENABLE:  scroll_enable_reg  <= cfg_data[0];
                CFG_MESSAGE_LENGTH: message_length_reg <= cfg_data[MSG_LEN_W-1:0];
                default:            scroll_period_reg  <= scroll_period_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Active chain width. A device count of zero acts as one device, and
    // counts beyond the built chain saturate at its length.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (device_count_reg == '0)
        begin
            active_devs = DEVCNT_W'(1);
        end
        else if (device_count_reg > DEVCNT_W'(MAX_DEVICES))
        begin
            active_devs = DEVCNT_W'(MAX_DEVICES);
        end
        else
        begin
            active_devs = device_count_reg;
        end
    end

    assign active_width = {active_devs, 3'b000};
    assign top_idx      = COL_W'(active_width - 7'd1);

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // A tick fires a step once the counter has reached the period; the step
    // only does work while scrolling is armed and enabled.
    assign step_fire = in_fire && (func == FUNC_TICK)
                       && (tick_count_reg >= scroll_period_reg)
                       && running_reg && scroll_enable_reg;

    // After the fifth glyph column a blank separator goes out and the
    // character index moves on, wrapping at the message length.
    always_comb
    begin
        blank_step = (font_column_reg >= GLYPH_COLS);
        idx_step   = blank_step ? (MSG_LEN_W'(char_index_reg) + MSG_LEN_W'(1))
                                : MSG_LEN_W'(char_index_reg);
        if (idx_step >= message_length_reg)
        begin
            idx_step = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        tick_count_next  = tick_count_reg;
        char_index_next  = char_index_reg;
        font_column_next = font_column_reg;
        running_next     = running_reg;
        blank_next       = blank_reg;
        col_sel_next     = col_sel_reg;
        frame_next       = frame_reg;
        col_ctl          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (func == FUNC_START))
                begin
                    running_next = 1'b1;
                end
                if (in_fire && (func == FUNC_TICK))
                begin
                    if (tick_count_reg < scroll_period_reg)
                    begin
                        tick_count_next = tick_count_reg + PERIOD_W'(1);
                    end
                    else
                    begin
                        tick_count_next = '0;
                    end
                end
                if (step_fire)
                begin
                    char_index_next = idx_step[SLOT_W-1:0];
                    blank_next      = blank_step;
                    col_sel_next    = font_column_reg;
                    if (blank_step)
                    begin
                        font_column_next = '0;
                    end
                    else
                    begin
                        font_column_next = font_column_reg + FONT_COL_W'(1);
                    end
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // Message RAM data for the current character is valid now.
                col_ctl.shift  = 1'b1;
                col_ctl.append = 1'b1;
                col_ctl.data   = blank_reg ? BLANK_COL : glyph_col(ram_rdata, col_sel_reg);
                frame_next     = '0;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_fire)
                begin
                    // Rotate so the next column reaches the head.
                    col_ctl.shift  = 1'b1;
                    col_ctl.append = 1'b0;
                    frame_next     = frame_reg + COL_W'(1);
                    if (frame_reg == top_idx)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tick_count_reg  <= '0;
            char_index_reg  <= '0;
            font_column_reg <= '0;
            running_reg     <= 1'b0;
            blank_reg       <= 1'b0;
            col_sel_reg     <= '0;
            frame_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            tick_count_reg  <= tick_count_next;
            char_index_reg  <= char_index_next;
            font_column_reg <= font_column_next;
            running_reg     <= running_next;
            blank_reg       <= blank_next;
            col_sel_reg     <= col_sel_next;
            frame_reg       <= frame_next;
        end
    end

    // ------------------------------------------------------------------
    // Message RAM: character writes, and the read of the character that a
    // scroll step shows, share its single port.
    // ------------------------------------------------------------------
    assign ram_we   = in_fire && (func == FUNC_WRITE);
    assign ram_re   = step_fire;
    assign ram_addr = ram_we ? slot_map[char_slot] : slot_map[char_index_next];

    stme_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (char_code),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Column store as a shift line; the head column is the row data.
    // ------------------------------------------------------------------
    stme_column_line #(
        .NUM_COLS (NUM_COLS)
    ) u_columns (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (col_ctl),
        .top_idx (top_idx),
        .head    (col_head)
    );

    // Frame fields follow the frame counter: eight rows to each device.
    assign frame_dev      = frame_reg >> 3;
    assign chain_position = CHAIN_W'(frame_dev);
    assign row_address    = ROW_ADDR_W'(frame_reg[2:0]) + ROW_ADDR_W'(1);
    assign row_data       = col_head;
    assign last           = (frame_reg == top_idx);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while frames are pending");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("engine did not return to idle after the final frame");

    a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |=> (out_valid && frame_reg == '0))
        else $error("scroll step did not start at the first frame");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_reg <= top_idx))
        else $error("frame counter ran past the active chain");

    a_font_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        font_column_reg <= GLYPH_COLS)
        else $error("font column beyond the separator column");

endmodule
`default_nettype wire

[sim/tb_scrolling_text_matrix_engine.sv]
`timescale 1ns / 100ps
// ============================================================================
// Scrolling text matrix engine testbench
// Drives message writes, start commands and ticks into the engine and
// predicts every row frame with an in-house copy of the scroll logic and
// font. Each frame from the engine is compared field by field against the
// oldest predicted frame. Both channels idle at random, and the run covers
// several register settings, including their extremes.
// ============================================================================
module tb_scrolling_text_matrix_engine;
    import stme_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int ITEM_TARGET   = 270;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    localparam int MAX_CHAIN      = 8;
    localparam int MSG_SLOTS      = 256;
    localparam int STORE_COLUMNS  = MAX_CHAIN * ROWS_PER_DEV;
    localparam int FIRST_PRINT    = 32;
    localparam int LAST_PRINT     = 126;
    localparam int GLYPH_WIDTH    = 5;

    // Function code 3 has no meaning; the engine must drop such an item.
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // Font for codes 32..126, five columns per code, leftmost column in the
    // top byte. Bit 0 of a column is the top row of the glyph.
    localparam logic [39:0] FONT [95] = '{
        40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0371090503, 40'h3649494936,
        40'h064949291E, 40'h006C6C0000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F4949493E,
        40'h3E41414122, 40'h7F4141413E, 40'h7F49494949, 40'h7F09090901, 40'h3E4149493A,
        40'h7F0808087F, 40'h41417F4141, 40'h3041413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09091966, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h0F3040300F,
        40'h3F4038403F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h7F41410000,
        40'h0204081020, 40'h000041417F, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7804080478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h0814147C00, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804040804
    };

    // One row frame as it leaves the engine.
    typedef struct packed {
        logic [CHAIN_W-1:0]    chain;
        logic [ROW_ADDR_W-1:0] row;
        logic [COL_DATA_W-1:0] data;
        logic                  last;
    } row_frame_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the engine state, turns every
    // accepted item into the row frames it should produce, and checks the
    // frames that come out in order.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [PERIOD_W-1:0]   period_reg;
        logic [DEVCNT_W-1:0]   devices_reg;
        logic                  enable_reg;
        logic [MSG_LEN_W-1:0]  length_reg;

        logic [COL_DATA_W-1:0] column_store [STORE_COLUMNS];
        logic [CODE_W-1:0]     message [MSG_SLOTS];
        bit                    slot_written [MSG_SLOTS];
        logic [PERIOD_W-1:0]   tick_count;
        logic [SLOT_W-1:0]     char_index;
        logic [FONT_COL_W-1:0] font_column;
        bit                    running;

        row_frame_t            frames_due [$];
        int                    failures;
        int                    reported;

        function new();
            period_reg  = '0;
            devices_reg = 4'd1;
            enable_reg  = 1'b0;
            length_reg  = 9'd1;
            foreach (column_store[i]) column_store[i] = '0;
            foreach (message[i]) begin
                message[i]      = '0;
                slot_written[i] = 1'b0;
            end
            tick_count  = '0;
            char_index  = '0;
            font_column = '0;
            running     = 1'b0;
            failures    = 0;
            reported    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_SCROLL_PERIOD:  period_reg  = value[PERIOD_W-1:0];
                CFG_DEVICE_COUNT:   devices_reg = value[DEVCNT_W-1:0];
                CFG_SCROLL_ENABLE:  enable_reg  = value[0];
                CFG_MESSAGE_LENGTH: length_reg  = value[MSG_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COL_DATA_W-1:0] glyph_column(logic [CODE_W-1:0] code,
                                                    logic [FONT_COL_W-1:0] col);
            logic [39:0] bits;
            if (int'(code) < FIRST_PRINT || int'(code) > LAST_PRINT || int'(col) >= GLYPH_WIDTH)
            begin
                return 8'h00;
            end
            bits = FONT[int'(code) - FIRST_PRINT];
            return bits[39 - 8 * int'(col) -: 8];
        endfunction

        // One scroll step: shift the active columns left, append the next
        // glyph or separator column, then queue one frame per device and row.
        function void scroll_step();
            int                    devices;
            int                    width;
            int                    idx;
            int                    d;
            int                    r;
            bit                    blank;
            logic [COL_DATA_W-1:0] fresh;
            row_frame_t            frame;
            devices = int'(devices_reg);
            if (devices == 0) devices = 1;
            if (devices > MAX_CHAIN) devices = MAX_CHAIN;
            width = devices * ROWS_PER_DEV;
            idx   = int'(char_index);
            blank = 1'b0;
            // After the fifth glyph column comes a blank separator, and the
            // index moves on to the next character.
            if (int'(font_column) >= GLYPH_WIDTH) begin
                idx++;
                font_column = '0;
                blank       = 1'b1;
            end
            // The wrap check runs on every step, so a shortened message pulls
            // the index back to zero even in the middle of a character.
            if (idx >= int'(length_reg)) idx = 0;
            char_index = SLOT_W'(idx);
            if (blank) begin
                fresh = 8'h00;
            end else begin
                fresh       = glyph_column(message[char_index], font_column);
                font_column = font_column + 1'b1;
            end
            for (d = 0; d < width - 1; d++) column_store[d] = column_store[d + 1];
            column_store[width - 1] = fresh;
            for (d = 0; d < devices; d++) begin
                for (r = 0; r < ROWS_PER_DEV; r++) begin
                    frame.chain = CHAIN_W'(d);
                    frame.row   = ROW_ADDR_W'(r + 1);
                    frame.data  = column_store[d * ROWS_PER_DEV + r];
                    frame.last  = (d == devices - 1) && (r == ROWS_PER_DEV - 1);
                    frames_due.push_back(frame);
                end
            end
        endfunction

        function void note_item(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] slot,
                                logic [CODE_W-1:0] code);
            case (f)
                FUNC_WRITE: begin
                    message[slot]      = code;
                    slot_written[slot] = 1'b1;
                end
                FUNC_START: running = 1'b1;
                FUNC_TICK: begin
                    if (tick_count < period_reg) begin
                        tick_count = tick_count + 1'b1;
                    end else begin
                        tick_count = '0;
                        if (running && enable_reg) scroll_step();
                    end
                end
                default: ;
            endcase
        endfunction

        // Slot that the next firing step would read, or -1 when that step
        // would read nothing (blank separator, or scrolling is idle).
        function int next_read_slot();
            int idx;
            if (!running || !enable_reg || int'(font_column) >= GLYPH_WIDTH) return -1;
            idx = int'(char_index);
            if (idx >= int'(length_reg)) idx = 0;
            return idx;
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function void check_frame(logic [CHAIN_W-1:0] chain, logic [ROW_ADDR_W-1:0] row,
                                  logic [COL_DATA_W-1:0] data, logic lst);
            row_frame_t want;
            if (frames_due.size() == 0) begin
                failures++;
                if (reported < REPORT_MAX)
                    $display("%0t: unexpected frame chain %0d row %0d data %02h last %0b",
                             $realtime, chain, row, data, lst);
                reported++;
                return;
            end
            want = frames_due.pop_front();
            if (chain !== want.chain || row !== want.row || data !== want.data
                || lst !== want.last) begin
                failures++;
                if (reported < REPORT_MAX) begin
                    $display("%0t: frame differs, expected chain %0d row %0d data %02h last %0b",
                             $realtime, want.chain, want.row, want.data, want.last);
                    $display("%0t: got chain %0d row %0d data %02h last %0b",
                             $realtime, chain, row, data, lst);
                end
                reported++;
            end
        endfunction

        function void close_out();
            if (frames_due.size() != 0) begin
                failures++;
                $display("%0d expected frames never arrived", frames_due.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the engine under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [FUNC_W-1:0]     func;
    logic [SLOT_W-1:0]     char_slot;
    logic [CODE_W-1:0]     char_code;
    logic                  out_valid;
    logic                  out_ready;
    logic [CHAIN_W-1:0]    chain_position;
    logic [ROW_ADDR_W-1:0] row_address;
    logic [COL_DATA_W-1:0] row_data;
    logic                  last;

    frame_scoreboard sb;
    int              items_done;
    int              cycle_count;
    bit              calm;          // set for the last part of the run: no idling
    bit              hold_request;  // asks the receiver for one long hold-off

    scrolling_text_matrix_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .char_slot      (char_slot),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .chain_position (chain_position),
        .row_address    (row_address),
        .row_data       (row_data),
        .last           (last)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge, where the values
    // driven at the previous falling edge are settled.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) sb.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready) sb.note_item(func, char_slot, char_code);
            if (out_valid && out_ready) sb.check_frame(chain_position, row_address, row_data, last);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls in bursts of random length, and once holds off
    // for a long stretch so the engine backs up and stops taking items.
    // ------------------------------------------------------------------------
    initial begin : frame_sink
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // The run ends here if the engine hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Each is entered at a falling edge and returns at one.
    // ------------------------------------------------------------------------

    // Offers one item and holds it until the engine takes it. A gap, if one
    // is taken, drops valid first so that it never falls and rises in the
    // same step.
    task automatic offer(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                         input logic [CODE_W-1:0] c);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        char_slot <= s;
        char_code <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (f != FUNC_NONE) items_done++;
        @(negedge clk);
    endtask

    // Mostly printable codes, with the full 7-bit range mixed in.
    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 3) != 0) return CODE_W'($urandom_range(FIRST_PRINT, LAST_PRINT));
        return CODE_W'($urandom_range(0, 127));
    endfunction

    // A tick, preceded by a write of the slot it is about to show when that
    // slot has never been written: the message store has no reset value.
    task automatic send_tick();
        int slot;
        slot = sb.next_read_slot();
        if (slot >= 0 && !sb.slot_written[slot]) offer(FUNC_WRITE, SLOT_W'(slot), pick_code());
        offer(FUNC_TICK, SLOT_W'($urandom), CODE_W'($urandom));
    endtask

    // Stops offering and waits until every predicted frame has come out,
    // then lets a settle time pass for an item that produces nothing.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Writes all four registers while the engine is idle.
    task automatic configure(input logic [PERIOD_W-1:0] period, input logic [DEVCNT_W-1:0] devices,
                             input logic enable, input logic [MSG_LEN_W-1:0] length);
        wait_idle();
        put_reg(CFG_SCROLL_PERIOD, CFG_DATA_W'(period));
        put_reg(CFG_DEVICE_COUNT, CFG_DATA_W'(devices));
        put_reg(CFG_SCROLL_ENABLE, CFG_DATA_W'(enable));
        put_reg(CFG_MESSAGE_LENGTH, CFG_DATA_W'(length));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                   phase;
        int                   body;
        int                   steps;
        int                   k;
        int                   pick;
        logic [PERIOD_W-1:0]  period_pick;
        logic [DEVCNT_W-1:0]  devices_pick;
        logic                 enable_pick;
        logic [MSG_LEN_W-1:0] length_pick;

        sb           = new();
        items_done   = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_SCROLL_PERIOD;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_TICK;
        char_slot    = '0;
        char_code    = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With the reset settings scrolling is neither
        // enabled nor armed, so a tick only counts.
        offer(FUNC_TICK, 8'h00, 7'h00);

        // A two-character message: the last printable code, then a code
        // below the printable range that must scroll as blank columns. The
        // top slot takes the top code but is never shown.
        configure(16'd0, 4'd1, 1'b1, 9'd2);
        offer(FUNC_WRITE, 8'd0, 7'd126);
        offer(FUNC_WRITE, 8'd1, 7'd0);
        offer(FUNC_WRITE, 8'd255, 7'd127);
        offer(FUNC_NONE, 8'hFF, 7'h7F);       // unknown function, dropped
        offer(FUNC_TICK, 8'hA5, 7'h5A);       // still not armed
        offer(FUNC_START, 8'h00, 7'h00);
        repeat (6) send_tick();               // five glyph columns and a separator
        offer(FUNC_START, 8'h5A, 7'h25);      // start while running keeps the position
        repeat (3) send_tick();

        // Longest period with a device count above the chain size and a zero
        // message length: the ticks only count up.
        configure(16'hFFFF, 4'd15, 1'b1, 9'd0);
        repeat (3) send_tick();
        // Lowering the period below the count makes the next tick fire.
        configure(16'd0, 4'd15, 1'b1, 9'd0);
        repeat (2) send_tick();
        // A device count of zero acts as one; with scrolling disabled a step
        // neither shifts nor emits.
        configure(16'd0, 4'd0, 1'b0, 9'd511);
        send_tick();
        configure(16'd0, 4'd0, 1'b1, 9'd511);
        send_tick();

        // Random part: each phase picks settings, writes a message, arms
        // scrolling and ticks, with some noise mixed in.
        phase = 0;
        while (items_done < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)      period_pick = PERIOD_W'($urandom_range(0, 2));
            else if (pick < 8) period_pick = PERIOD_W'($urandom_range(3, 6));
            else if (pick == 8) period_pick = 16'hFFFF;
            else               period_pick = PERIOD_W'($urandom);

            pick = $urandom_range(0, 9);
            if (pick < 6)      devices_pick = DEVCNT_W'($urandom_range(1, 3));
            else if (pick < 9) devices_pick = DEVCNT_W'($urandom_range(4, 8));
            else               devices_pick = ($urandom_range(0, 1) == 0) ? 4'd0
                                              : DEVCNT_W'($urandom_range(9, 15));

            enable_pick = ($urandom_range(0, 9) != 0);

            pick = $urandom_range(0, 9);
            if (pick < 7)       length_pick = MSG_LEN_W'($urandom_range(1, 12));
            else if (pick == 7) length_pick = 9'd0;
            else if (pick == 8) length_pick = ($urandom_range(0, 1) == 0) ? 9'd256 : 9'd511;
            else                length_pick = MSG_LEN_W'($urandom);

            // The second phase runs the full chain at top speed while the
            // receiver holds off, so the engine backs up.
            if (phase == 1) begin
                period_pick  = 16'd0;
                devices_pick = 4'd8;
                enable_pick  = 1'b1;
            end
            configure(period_pick, devices_pick, enable_pick, length_pick);
            if (phase == 1) hold_request = 1'b1;
            calm = (items_done >= ITEM_TARGET * 3 / 4);

            body = (length_pick == 0) ? 1 : ((length_pick > 12) ? 12 : int'(length_pick));
            for (k = 0; k < body; k++) begin
                if ($urandom_range(0, 4) != 0) offer(FUNC_WRITE, SLOT_W'(k), pick_code());
            end
            if ($urandom_range(0, 5) != 0) offer(FUNC_START, SLOT_W'($urandom), CODE_W'($urandom));

            steps = $urandom_range(8, 30);
            for (k = 0; k < steps; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    offer(FUNC_NONE, SLOT_W'($urandom), CODE_W'($urandom));
                else if (pick == 1)
                    offer(FUNC_WRITE, SLOT_W'($urandom_range(0, 255)),
                          CODE_W'($urandom_range(0, 127)));
                else if (pick == 2)
                    offer(FUNC_START, SLOT_W'($urandom), CODE_W'($urandom));
                else
                    send_tick();
            end
            phase++;
        end

        wait_idle();
        sb.close_out();
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
